// ===== rtl/core/ipacl_pkg.sv =====
// Shared widths, status codes and the prefix mask function for the IPv4 ACL block.
package ipacl_pkg;

	localparam int ADDR_W       = 32;
	localparam int LEN_W        = 6;
	localparam int MAX_RULES_DEF = 64;
	localparam logic [LEN_W-1:0] LEN_MAX = 6'd32;

	typedef enum logic [1:0] {
		STAT_QUERY = 2'd0,
		STAT_ADDED = 2'd1,
		STAT_DUP   = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	// Build a left-aligned mask of len ones; len is at most 32.
	function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] sh;
		sh = LEN_MAX - len;
		if (len == '0) begin
			return '0;
		end
		return {ADDR_W{1'b1}} << sh;
	endfunction

endpackage

// ===== rtl/core/ipacl_req_if.sv =====
// Request channel: command, address, prefix length and action with valid/ready.
interface ipacl_req_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [ipacl_pkg::ADDR_W-1:0]  address;
	logic [ipacl_pkg::LEN_W-1:0]   prefix_len;
	logic                          allow_rule;

	modport source (output valid, command, address, prefix_len, allow_rule, input ready);
	modport sink   (input valid, command, address, prefix_len, allow_rule, output ready);
endinterface

// ===== rtl/core/ipacl_rsp_if.sv =====
// Response channel: verdict, status and match flag with valid/ready.
interface ipacl_rsp_if;
	logic       valid;
	logic       ready;
	logic       permitted;
	logic [1:0] status;
	logic       rule_matched;

	modport source (output valid, permitted, status, rule_matched, input ready);
	modport sink   (input valid, permitted, status, rule_matched, output ready);
endinterface

// ===== rtl/core/ipv4_prefix_acl_first_match.sv =====
// IPv4 first-match access list: a rule memory scanned by one shared compare unit.
// Steps: accept, scan the stored rules in order up to the first hit, finish once the
// response register is free. The scan does one registered rule read a cycle.
// Not ready while an item is scanned or finished; the response register lets the next request in.
// Reset (arst_n low, asynchronous) empties the table and drops any pending response;
// rule memory contents are not cleared, only entries below the rule count are read.
module ipv4_prefix_acl_first_match #(
	parameter int MAX_RULES = ipacl_pkg::MAX_RULES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ipacl_req_if.sink   req,
	ipacl_rsp_if.source rsp
);

	localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int CNT_W = $clog2(MAX_RULES + 1);
	localparam int ENT_W = ipacl_pkg::ADDR_W + ipacl_pkg::LEN_W + 1;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_RULES);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	typedef struct packed {
		logic [ipacl_pkg::ADDR_W-1:0] prefix;
		logic [ipacl_pkg::LEN_W-1:0]  len;
		logic                         allows;
	} rule_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              idx_q;
	logic                          chk_vld_q;
	logic                          found_q;
	logic                          hit_allow_q;
	logic                          cmd_q;
	logic [ipacl_pkg::ADDR_W-1:0]  addr_q;
	logic [ipacl_pkg::ADDR_W-1:0]  pfx_q;
	logic [ipacl_pkg::LEN_W-1:0]   len_q;
	logic                          allow_q;

	logic                          ovalid_q;
	logic                          permitted_q;
	logic [1:0]                    status_q;
	logic                          matched_q;

	rule_t                         mem_q [MAX_RULES];
	rule_t                         rd_q;

	logic                          accept;
	logic                          issue;
	logic                          hit;
	logic                          out_free;
	logic                          mem_we;
	logic [ipacl_pkg::LEN_W-1:0]   len_sat;
	logic [ipacl_pkg::ADDR_W-1:0]  cmp_lhs;
	ipacl_pkg::status_t            add_status;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !ovalid_q || rsp.ready;
	assign issue     = (state_q == ST_SCAN) && (idx_q < count_q);

	// Saturate the incoming prefix length at 32
	assign len_sat = (req.prefix_len > ipacl_pkg::LEN_MAX) ? ipacl_pkg::LEN_MAX : req.prefix_len;

	// Shared compare: query masks the address by the rule length, add matches prefix and length
	always_comb begin
		if (cmd_q) begin
			cmp_lhs = addr_q & ipacl_pkg::len_mask(rd_q.len);
			hit     = chk_vld_q && (cmp_lhs == rd_q.prefix);
		end else begin
			cmp_lhs = pfx_q;
			hit     = chk_vld_q && (cmp_lhs == rd_q.prefix) && (rd_q.len == len_q);
		end
	end

	// Decide the add outcome once the scan is over
	always_comb begin
		if (found_q) begin
			add_status = ipacl_pkg::STAT_DUP;
		end else if (count_q == CNT_FULL) begin
			add_status = ipacl_pkg::STAT_FULL;
		end else begin
			add_status = ipacl_pkg::STAT_ADDED;
		end
	end

	assign mem_we = (state_q == ST_DONE) && out_free && !cmd_q
		&& (add_status == ipacl_pkg::STAT_ADDED);

	// Rule memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[count_q[IDX_W-1:0]] <= '{prefix: pfx_q, len: len_q, allows: allow_q};
		end
		rd_q <= mem_q[idx_q[IDX_W-1:0]];
	end

	// Latch the request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.command;
			addr_q  <= req.address;
			pfx_q   <= req.address & ipacl_pkg::len_mask(len_sat);
			len_q   <= len_sat;
			allow_q <= req.allow_rule;
		end
	end

	// Sequencer: accept, scan rules one per cycle, finish into the response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			chk_vld_q   <= 1'b0;
			found_q     <= 1'b0;
			hit_allow_q <= 1'b0;
			ovalid_q    <= 1'b0;
			permitted_q <= 1'b0;
			status_q    <= '0;
			matched_q   <= 1'b0;
		end else begin
			if (ovalid_q && rsp.ready && !(state_q == ST_DONE && out_free)) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q     <= '0;
						chk_vld_q <= 1'b0;
						found_q   <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					chk_vld_q <= issue;
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (hit) begin
						found_q     <= 1'b1;
						hit_allow_q <= rd_q.allows;
						state_q     <= ST_DONE;
					end else if (!issue) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						if (cmd_q) begin
							permitted_q <= found_q ? hit_allow_q : 1'b1;
							status_q    <= ipacl_pkg::STAT_QUERY;
							matched_q   <= found_q;
						end else begin
							permitted_q <= 1'b0;
							status_q    <= add_status;
							matched_q   <= 1'b0;
							if (add_status == ipacl_pkg::STAT_ADDED) begin
								count_q <= count_q + 1'b1;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = ovalid_q;
	assign rsp.permitted    = permitted_q;
	assign rsp.status       = status_q;
	assign rsp.rule_matched = matched_q;

endmodule
